// ===== hdl/mhpq_pkg.sv =====
// Shared types and codes for the min-heap priority queue.
package mhpq_pkg;

  // Request codes carried on req_type.
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Status codes returned on error_code.
  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } mhpq_err_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
  } mhpq_op_t;

endpackage

// ===== hdl/mhpq_cell.sv =====
// One slot of the sorted chain: holds a value and its valid flag.
module mhpq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mhpq_pkg::mhpq_op_t           op,
  input  logic signed [DATA_WIDTH-1:0] new_value,
  input  logic signed [DATA_WIDTH-1:0] left_value,
  input  logic                         left_valid,
  input  logic                         left_lt,
  input  logic signed [DATA_WIDTH-1:0] right_value,
  input  logic                         right_valid,
  output logic signed [DATA_WIDTH-1:0] value,
  output logic                         valid,
  output logic                         lt
);

  // An empty slot counts as larger than anything.
  assign lt = !valid || (new_value < value);

  always_ff @(posedge clk) begin
    if (op.push) begin
      if (left_lt) begin
        value <= left_value;
      end else if (lt) begin
        value <= new_value;
      end
    end else if (op.pop) begin
      value <= right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.push) begin
      if (left_lt) begin
        valid <= left_valid;
      end else if (lt) begin
        valid <= 1'b1;
      end
    end else if (op.pop) begin
      valid <= right_valid;
    end
  end

endmodule

// ===== hdl/min_heap_priority_queue_top.sv =====
// Top level of the min-heap priority queue: sorted chain of cells plus handshake.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+------------------------------------------------
//   in      | in_valid  | in_ready  | req_type, push_value
//   out     | out_valid | out_ready | popped_value, min_value, element_count,
//           |           |           | is_empty, error_code
//
// The chain updates at the accepting edge and the result sits in the output
// register from the next cycle on; each cell needs only a single compare
// against the broadcast push value.
// A new item is accepted whenever the output register is empty or being taken,
// so back-to-back items run at one per cycle; a stalled output holds the input.
// Reset clears the cell valid flags, the count and the output valid; no sweep.
module min_heap_priority_queue_top #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  localparam int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic signed [DATA_WIDTH-1:0] push_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] popped_value,
  output logic signed [DATA_WIDTH-1:0] min_value,
  output logic [CW-1:0]                element_count,
  output logic                         is_empty,
  output logic [1:0]                   error_code
);

  // Chain taps: each cell sees its neighbors' values at fixed places.
  logic signed [DATA_WIDTH-1:0] cell_value [CAPACITY];
  logic                         cell_valid [CAPACITY];
  logic                         cell_lt    [CAPACITY];

  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               accept;
  logic               full;
  logic               empty;
  mhpq_pkg::mhpq_op_t op;
  mhpq_pkg::mhpq_err_t err;
  logic signed [DATA_WIDTH-1:0] popped_next;
  logic signed [DATA_WIDTH-1:0] min_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);

  // Decode the request; a failed request leaves the chain alone.
  always_comb begin
    op          = '0;
    err         = mhpq_pkg::ERR_OK;
    count_next  = count;
    popped_next = '0;
    min_next    = empty ? '0 : cell_value[0];
    if (accept) begin
      if (req_type == mhpq_pkg::REQ_PUSH) begin
        if (full) begin
          err = mhpq_pkg::ERR_FULL;
        end else begin
          op.push    = 1'b1;
          count_next = count + CW'(1);
          // Head cell's compare tells whether the new value becomes the minimum.
          min_next   = cell_lt[0] ? push_value : cell_value[0];
        end
      end else begin
        if (empty) begin
          err = mhpq_pkg::ERR_EMPTY;
        end else begin
          op.pop      = 1'b1;
          count_next  = count - CW'(1);
          popped_next = cell_value[0];
          min_next    = (count > CW'(1)) ? cell_value[1] : '0;
        end
      end
    end
  end

  // Build the chain: on push the tail shifts right past the insert point,
  // on pop everything shifts left one cell.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] l_value;
    logic                         l_valid;
    logic                         l_lt;
    logic signed [DATA_WIDTH-1:0] r_value;
    logic                         r_valid;

    if (i == 0) begin : g_head
      assign l_value = '0;
      assign l_valid = 1'b0;
      assign l_lt    = 1'b0;
    end else begin : g_mid_l
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_lt    = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end

    mhpq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .new_value  (push_value),
      .left_value (l_value),
      .left_valid (l_valid),
      .left_lt    (l_lt),
      .right_value(r_value),
      .right_valid(r_valid),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .lt         (cell_lt[i])
    );
  end

  // Hold the count of stored values.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register: load on accept, drop valid once the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value  <= popped_next;
      min_value     <= min_next;
      element_count <= count_next;
      is_empty      <= (count_next == '0);
      error_code    <= err;
    end
  end

  // Count and head cell must agree on emptiness.
  a_count_head: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == !cell_valid[0])
    else $error("count disagrees with head cell valid");

  // Count never exceeds capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  // A failed request removes nothing and changes no count.
  a_err_noop: assert property (@(posedge clk) disable iff (rst)
    accept && err != mhpq_pkg::ERR_OK |=> out_valid && popped_value == '0 &&
      count == $past(count))
    else $error("failed request changed the queue");

  // A pop that succeeds shrinks the count by one.
  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    op.pop |=> count == $past(count) - CW'(1))
    else $error("pop did not decrement count");

endmodule
